// File: src/rmq_pkg.sv
// Shared types, constants and sizing for the rotation matrix to quaternion unit.
package rmq_pkg;

  localparam int unsigned FracBitsDef = 14;
  localparam int unsigned ElemW = 16;

  typedef struct packed {
    logic signed [ElemW-1:0] m00;
    logic signed [ElemW-1:0] m01;
    logic signed [ElemW-1:0] m02;
    logic signed [ElemW-1:0] m10;
    logic signed [ElemW-1:0] m11;
    logic signed [ElemW-1:0] m12;
    logic signed [ElemW-1:0] m20;
    logic signed [ElemW-1:0] m21;
    logic signed [ElemW-1:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] qw;
    logic signed [ElemW-1:0] qx;
    logic signed [ElemW-1:0] qy;
    logic signed [ElemW-1:0] qz;
  } rmq_out_t;

  typedef enum logic [1:0] {
    PivW = 2'd0,
    PivX = 2'd1,
    PivY = 2'd2,
    PivZ = 2'd3
  } rmq_piv_e;

endpackage

// File: src/rmq_sqrt_cell.sv
// One stage of the pipelined square root: one result bit per cell.
module rmq_sqrt_cell #(
  parameter int unsigned RadW = 48,
  parameter int unsigned RootW = 24,
  parameter int unsigned Bit = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RadW-1:0]  rem_i,
  input  logic [RootW-1:0] root_i,
  output logic [RadW-1:0]  rem_o,
  output logic [RootW-1:0] root_o
);

  logic [RadW-1:0]  rem_d, rem_q, trial;
  logic [RootW-1:0] root_d, root_q;

  // trial = (2*root + 2^Bit) << Bit, with root holding the bits decided above Bit
  always_comb begin
    trial = ((RadW'(root_i) << (Bit + 1)) | (RadW'(1) << (2 * Bit)));
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = root_i | (RootW'(1) << Bit);
    end else begin
      rem_d  = rem_i;
      root_d = root_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// File: src/rmq_div_cell.sv
// One stage of the restoring divider chain: one quotient bit per cell, three lanes.
module rmq_div_cell #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 24,
  parameter int unsigned Bit = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DenW-1:0]      den_i,
  input  logic [2:0][NumW-1:0] rem_i,
  input  logic [2:0][NumW-1:0] quo_i,
  output logic [DenW-1:0]      den_o,
  output logic [2:0][NumW-1:0] rem_o,
  output logic [2:0][NumW-1:0] quo_o
);

  localparam int unsigned WideW = NumW + DenW;

  logic [2:0][NumW-1:0] rem_d, rem_q, quo_d, quo_q;
  logic [DenW-1:0]      den_q;
  logic [WideW-1:0]     sub;

  always_comb begin
    sub = WideW'(den_i) << Bit;
    for (int l = 0; l < 3; l++) begin
      if (WideW'(rem_i[l]) >= sub) begin
        rem_d[l] = rem_i[l] - NumW'(sub);
        quo_d[l] = quo_i[l] | (NumW'(1) << Bit);
      end else begin
        rem_d[l] = rem_i[l];
        quo_d[l] = quo_i[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_i;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;

endmodule

// File: src/rotation_matrix_to_quaternion_unit.sv
// Top level: pivot select, sqrt cell chain, divider cell chain, output register.
//
// Fully pipelined: one matrix is taken per clock while the output is not
// stalled. The stages are 1 pivot stage, (FRAC_BITS+23)/2 sqrt cells,
// FRAC_BITS+19 divider cells and the output register: 18 sqrt and 33
// divider cells at FRAC_BITS=14. The depth is set by the bit-per-cell
// square root and divider chains. The whole pipe advances only when the
// output register is free or being taken, so a stall at the output holds
// every stage; in_ready_o drops only then.
module rotation_matrix_to_quaternion_unit #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rmq_pkg::rmq_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rmq_pkg::rmq_out_t out_data_o
);

  // P < 2^17 + 2^FRAC_BITS; radicand P << (FRAC_BITS+2)
  localparam int unsigned PW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int unsigned RadW  = PW + FRAC_BITS + 2;
  localparam int unsigned RootW = (RadW + 1) / 2;
  localparam int unsigned SqN   = RootW;
  localparam int unsigned NW    = 18;                 // |N| < 2^17
  // quotient bits: (|N|<<F + S/2)/S; S>=1 so < 2^(NW+F)
  localparam int unsigned NumW  = NW + FRAC_BITS + 1;
  localparam int unsigned DvN   = NumW;
  localparam int unsigned Depth = 1 + SqN + DvN;

  logic adv;
  logic out_valid_q;
  logic [Depth-1:0] vld_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[Depth-2:0], in_valid_i};
      out_valid_q <= vld_q[Depth-1];
    end
  end
  assign out_valid_o = out_valid_q;

  // ---- pivot stage
  logic signed [17:0] t, a00, a11, a22;
  logic signed [PW-1:0] p_d;
  logic signed [NW-1:0] n_d [3];
  rmq_pkg::rmq_piv_e piv_d;

  always_comb begin
    logic signed [PW-1:0] one;
    one = PW'(1) <<< FRAC_BITS;
    a00 = 18'(in_data_i.m00);
    a11 = 18'(in_data_i.m11);
    a22 = 18'(in_data_i.m22);
    t = a00 + a11 + a22;
    if (t > 0) begin
      piv_d = rmq_pkg::PivW;
      p_d = PW'(t) + one;
      n_d[0] = NW'(in_data_i.m21) - NW'(in_data_i.m12);
      n_d[1] = NW'(in_data_i.m02) - NW'(in_data_i.m20);
      n_d[2] = NW'(in_data_i.m10) - NW'(in_data_i.m01);
    end else if (a00 > a11 && a00 > a22) begin
      piv_d = rmq_pkg::PivX;
      p_d = one + PW'(a00) - PW'(a11) - PW'(a22);
      n_d[0] = NW'(in_data_i.m21) - NW'(in_data_i.m12);
      n_d[1] = NW'(in_data_i.m01) + NW'(in_data_i.m10);
      n_d[2] = NW'(in_data_i.m02) + NW'(in_data_i.m20);
    end else if (a11 > a22) begin
      piv_d = rmq_pkg::PivY;
      p_d = one + PW'(a11) - PW'(a00) - PW'(a22);
      n_d[0] = NW'(in_data_i.m02) - NW'(in_data_i.m20);
      n_d[1] = NW'(in_data_i.m01) + NW'(in_data_i.m10);
      n_d[2] = NW'(in_data_i.m12) + NW'(in_data_i.m21);
    end else begin
      piv_d = rmq_pkg::PivZ;
      p_d = one + PW'(a22) - PW'(a00) - PW'(a11);
      n_d[0] = NW'(in_data_i.m10) - NW'(in_data_i.m01);
      n_d[1] = NW'(in_data_i.m02) + NW'(in_data_i.m20);
      n_d[2] = NW'(in_data_i.m12) + NW'(in_data_i.m21);
    end
  end

  // side data carried alongside the chains
  typedef struct packed {
    logic [1:0]              piv;
    logic [2:0][NW-1:0]      n;
  } side_t;

  side_t side_q [Depth];
  logic [RadW-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0].piv <= piv_d;
      for (int l = 0; l < 3; l++) side_q[0].n[l] <= n_d[l];
      rad_q <= p_d[PW-1] ? '0 : (RadW'(p_d) << (FRAC_BITS + 2));
      for (int k = 1; k < Depth; k++) side_q[k] <= side_q[k-1];
    end
  end

  // ---- sqrt chain, msb first
  logic [RadW-1:0]  srem [SqN+1];
  logic [RootW-1:0] sroot [SqN+1];
  assign srem[0]  = rad_q;
  assign sroot[0] = '0;

  for (genvar g = 0; g < SqN; g++) begin : g_sq
    rmq_sqrt_cell #(.RadW(RadW), .RootW(RootW), .Bit(SqN - 1 - g)) u_cell (
      .clk_i, .en_i(adv),
      .rem_i(srem[g]), .root_i(sroot[g]),
      .rem_o(srem[g+1]), .root_o(sroot[g+1])
    );
  end

  logic [RootW-1:0] s_w;
  side_t sd_s;
  assign s_w  = sroot[SqN];
  assign sd_s = side_q[SqN];

  // ---- divider seed: (|N| << F) + S/2
  logic [2:0][NumW-1:0] d_num;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [NW-1:0] mag;
      mag = sd_s.n[l][NW-1] ? NW'(-sd_s.n[l]) : sd_s.n[l];
      d_num[l] = (NumW'(mag) << FRAC_BITS) + NumW'(s_w >> 1);
    end
  end

  logic [RootW-1:0]      dden [DvN+1];
  logic [2:0][NumW-1:0]  drem [DvN+1];
  logic [2:0][NumW-1:0]  dquo [DvN+1];
  assign dden[0] = s_w;
  assign drem[0] = d_num;
  assign dquo[0] = '0;

  for (genvar g = 0; g < DvN; g++) begin : g_dv
    rmq_div_cell #(.NumW(NumW), .DenW(RootW), .Bit(DvN - 1 - g)) u_cell (
      .clk_i, .en_i(adv),
      .den_i(dden[g]), .rem_i(drem[g]), .quo_i(dquo[g]),
      .den_o(dden[g+1]), .rem_o(drem[g+1]), .quo_o(dquo[g+1])
    );
  end

  // ---- final assembly
  side_t sd_e;
  logic [RootW-1:0] s_e;
  logic [3:0][15:0] q;
  assign sd_e = side_q[Depth - 1];
  assign s_e  = dden[DvN];

  function automatic logic [15:0] sat_q(input logic [NumW-1:0] m, input logic neg);
    logic [15:0] r;
    if (neg) r = (m > NumW'(32768)) ? 16'h8000 : 16'(-m);
    else     r = (m > NumW'(32767)) ? 16'h7fff : 16'(m);
    return r;
  endfunction

  always_comb begin
    logic [15:0] o [3];
    logic [RootW:0] pv;
    int j;
    for (int l = 0; l < 3; l++) o[l] = sat_q(dquo[DvN][l], sd_e.n[l][NW-1]);
    pv = ((RootW+1)'(s_e) + (RootW+1)'(2)) >> 2;
    j = 0;
    for (int k = 0; k < 4; k++) begin
      if (2'(k) == sd_e.piv) begin
        q[k] = (pv > (RootW+1)'(32767)) ? 16'h7fff : 16'(pv);
      end else begin
        q[k] = o[j[1:0]];
        j = j + 1;
      end
      if (s_e == '0) q[k] = '0;
    end
  end

  rmq_pkg::rmq_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.qw <= q[0];
      out_q.qx <= q[1];
      out_q.qy <= q[2];
      out_q.qz <= q[3];
    end
  end
  assign out_data_o = out_q;

endmodule

// File: src/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion unit.
module rmq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input rmq_pkg::rmq_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed under stall");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output empty");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

// File: bench/tb.sv
// Self-checking bench for the rotation matrix to quaternion unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits = rmq_pkg::FracBitsDef;
  localparam int unsigned Latency = 52;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  rmq_pkg::rmq_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  rmq_pkg::rmq_out_t out_data_o;

  rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FracBits)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rmq_pkg::rmq_in_t  matrix_q[$];
  rmq_pkg::rmq_out_t quat_q[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  bit in_taken = 1'b0;
  int unsigned n_piv[4] = '{0, 0, 0, 0};

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // n * ONE / s, nearest, ties away from zero
  function automatic logic signed [15:0] scaled_quot(longint n, longint unsigned s);
    longint unsigned mag;
    longint q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = longint'(((mag << FracBits) + s / 2) / s);
    return clip16((n < 0) ? -q : q);
  endfunction

  function automatic rmq_pkg::rmq_out_t quat_of(rmq_pkg::rmq_in_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint one, tr, p, n0, n1, n2;
    longint unsigned s;
    rmq_pkg::rmq_piv_e piv;
    logic signed [15:0] o0, o1, o2, pc;
    rmq_pkg::rmq_out_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    one = longint'(1) << FracBits;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      piv = rmq_pkg::PivW; p = tr + one;
      n0 = a21 - a12; n1 = a02 - a20; n2 = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      piv = rmq_pkg::PivX; p = one + a00 - a11 - a22;
      n0 = a21 - a12; n1 = a01 + a10; n2 = a02 + a20;
    end else if (a11 > a22) begin
      piv = rmq_pkg::PivY; p = one + a11 - a00 - a22;
      n0 = a02 - a20; n1 = a01 + a10; n2 = a12 + a21;
    end else begin
      piv = rmq_pkg::PivZ; p = one + a22 - a00 - a11;
      n0 = a10 - a01; n1 = a02 + a20; n2 = a12 + a21;
    end
    n_piv[piv]++;
    if (p < 0) p = 0;  // non-orthonormal input
    s = int_sqrt(longint'(p) << (FracBits + 2));
    if (s == 0) return '0;
    o0 = scaled_quot(n0, s);
    o1 = scaled_quot(n1, s);
    o2 = scaled_quot(n2, s);
    pc = clip16(longint'((s + 2) >> 2));
    case (piv)
      rmq_pkg::PivW: r = '{qw: pc, qx: o0, qy: o1, qz: o2};
      rmq_pkg::PivX: r = '{qw: o0, qx: pc, qy: o1, qz: o2};
      rmq_pkg::PivY: r = '{qw: o0, qx: o1, qy: pc, qz: o2};
      default: r = '{qw: o0, qx: o1, qy: o2, qz: pc};
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("ERROR word %0d %s: got %0d expected %0d", n_checked, what, got, want);
  endtask

  // driver: bursts and gaps, words change at the falling edge
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (gap_left > 0 || matrix_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_data_i <= matrix_q.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // receiver stall pattern: periodic runs plus random drops
  int unsigned rx_cnt = 0;
  always @(negedge clk_i) begin
    rx_cnt++;
    if (hold_off) out_ready_i <= 1'b0;
    else if (rx_cnt % 512 < 128) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  // long output stall while the sender keeps offering words
  initial begin
    wait (n_sent >= 700);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // monitor: records accepted inputs and checks accepted outputs
  always @(posedge clk_i) begin
    rmq_pkg::rmq_out_t want;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) begin
      quat_q.push_back(quat_of(in_data_i));
      n_sent++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quat_q.size() == 0) begin
        errors++;
        $display("ERROR unexpected quaternion word");
      end else begin
        want = quat_q.pop_front();
        if (out_data_o.qw !== want.qw) report_mismatch("qw", out_data_o.qw, want.qw);
        if (out_data_o.qx !== want.qx) report_mismatch("qx", out_data_o.qx, want.qx);
        if (out_data_o.qy !== want.qy) report_mismatch("qy", out_data_o.qy, want.qy);
        if (out_data_o.qz !== want.qz) report_mismatch("qz", out_data_o.qz, want.qz);
      end
      n_checked++;
    end
  end

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // roughly orthonormal: signed permutation with small perturbations
  function automatic rmq_pkg::rmq_in_t near_rotation();
    logic signed [15:0] e[9];
    int perm[3];
    int k, t;
    perm = '{0, 1, 2};
    for (k = 2; k > 0; k--) begin
      t = $urandom_range(0, k);
      {perm[k], perm[t]} = {perm[t], perm[k]};
    end
    for (k = 0; k < 9; k++) e[k] = 16'(int'($urandom_range(0, 4000)) - 2000);
    for (k = 0; k < 3; k++)
      e[3 * k + perm[k]] = $urandom_range(0, 1) ? 16'sd16384 - e[3 * k + perm[k]] / 4
                                                : -16'sd16384 - e[3 * k + perm[k]] / 4;
    return '{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  initial begin
    rmq_pkg::rmq_in_t m;
    int k;
    // identity, and each axis as pivot
    matrix_q.push_back('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
    matrix_q.push_back('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
    matrix_q.push_back('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
    matrix_q.push_back('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
    matrix_q.push_back('0);  // zero trace, ties fall through to z
    matrix_q.push_back('{-5000, 1, 2, 3, -5000, 4, 5, 6, -5000});  // three-way tie
    matrix_q.push_back('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768});  // full-scale negative diagonal
    matrix_q.push_back('{-32768, 32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768});
    matrix_q.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
    matrix_q.push_back('{32767, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767});
    matrix_q.push_back('{-32768, 32767, 32767, 32767, 32767, -32768, 32767, -32768, -32768});
    matrix_q.push_back('{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0});  // tiny trace
    matrix_q.push_back('{-16384, 32767, 32767, 32767, -16384, 32767, 32767, 32767, -16384});
    matrix_q.push_back('{0, 16384, 0, -16384, 0, 0, 0, 0, 16384});
    for (k = 0; k < 1500; k++) begin
      if (k % 4 == 3) begin
        for (int j = 0; j < 9; j++) m[16 * j +: 16] = rand_elem();
      end else begin
        m = near_rotation();
      end
      matrix_q.push_back(m);
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (matrix_q.size() == 0 && !in_valid_i);
    stim_done = 1'b1;
    wait (quat_q.size() == 0);
    repeat (Latency + 20) @(posedge clk_i);
    $display("Checked %0d quaternions from %0d matrices; pivots w/x/y/z: %0d/%0d/%0d/%0d",
             n_checked, n_sent, n_piv[0], n_piv[1], n_piv[2], n_piv[3]);
    if (errors == 0 && quat_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d quaternions outstanding", quat_q.size());
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: files.f
src/rmq_pkg.sv
src/rmq_sqrt_cell.sv
src/rmq_div_cell.sv
src/rotation_matrix_to_quaternion_unit.sv
src/rmq_checker.sv
bench/tb.sv
